// ===== sv/dsmi_pkg.sv =====
// Package for the docid sorted merge index.
// Holds status, mode and register index codes plus fixed widths.
// No dependencies.
package dsmi_pkg;

   localparam int LIMIT_W = 7;

   typedef logic [2:0]         status_type;
   typedef logic [1:0]         mode_type;
   typedef logic [0:0]         csr_index_type;
   typedef logic [LIMIT_W-1:0] csr_data_type;

   localparam status_type ST_OK     = 3'd0;
   localparam status_type ST_SKIP   = 3'd1;
   localparam status_type ST_FULL   = 3'd2;
   localparam status_type ST_OVF    = 3'd3;
   localparam status_type ST_BADPOS = 3'd4;

   localparam mode_type MODE_ADD   = 2'd0;
   localparam mode_type MODE_MERGE = 2'd1;
   localparam mode_type MODE_READ  = 2'd2;

   localparam csr_index_type CSR_AUTO_MERGE = 1'd0;
   localparam csr_index_type CSR_LIMIT      = 1'd1;

   localparam csr_data_type LIMIT_RESET = 7'd64;

endpackage

// ===== sv/dsmi_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Used for the pending buffer and both index banks. No dependencies.
module dsmi_ram #(
   parameter int WIDTH = 39,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== sv/docid_sorted_merge_index.sv =====
// Docid sorted merge index: an add answers from the idle state, a read through the
// read state. A merge picks the next pending docid by a full scan of the pending
// buffer, one scan per surviving pending entry plus a closing scan, then places the
// entry through the head and step states, and takes each old index entry through
// the head, capture and step states; the merged list goes to the other of two index
// banks. An add that triggers a merge reports when the merge ends. The block takes
// no item while a merge or read runs. Depends on dsmi_pkg and dsmi_ram.
module docid_sorted_merge_index #(
   parameter int INDEX_DEPTH   = 1024,
   parameter int PENDING_DEPTH = 64,
   parameter int DOCID_BITS    = 38
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  dsmi_pkg::mode_type                   req_mode,
   input  logic [7:0]                           req_key_low_byte,
   input  logic [DOCID_BITS-1:0]                req_docid,
   input  logic [$clog2(INDEX_DEPTH)-1:0]       req_read_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dsmi_pkg::status_type                 rsp_status,
   output logic [DOCID_BITS-1:0]                rsp_entry_docid,
   output logic                                 rsp_entry_positive,
   output logic [$clog2(INDEX_DEPTH+1)-1:0]     rsp_index_count,
   output logic [$clog2(PENDING_DEPTH+1)-1:0]   rsp_pending_count,
   output logic                                 rsp_merged,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  dsmi_pkg::csr_index_type              csr_index,
   input  dsmi_pkg::csr_data_type               csr_data
);
   import dsmi_pkg::*;

   localparam int EW  = DOCID_BITS + 1;
   localparam int IAW = $clog2(INDEX_DEPTH);
   localparam int ICW = $clog2(INDEX_DEPTH + 1);
   localparam int PAW = $clog2(PENDING_DEPTH);
   localparam int PCW = $clog2(PENDING_DEPTH + 1);
   localparam int LW  = (PCW > LIMIT_W) ? PCW : LIMIT_W;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_PSCAN, S_HEAD, S_HCAP, S_STEP
   } state_type;

   state_type          state_ff, state_in;
   logic               amen_ff, amen_in;
   csr_data_type       limit_ff, limit_in;
   logic [ICW-1:0]     isize_ff, isize_in;
   logic [PCW-1:0]     psize_ff, psize_in;
   logic [EW-1:0]      last_ff, last_in;
   logic               last_vld_ff, last_vld_in;
   logic               act_ff, act_in;
   status_type         saved_ff, saved_in;
   logic [PCW-1:0]     scan_ff, scan_in;
   logic               cap_ff, cap_in;
   logic [EW-1:0]      best_ff, best_in;
   logic               best_vld_ff, best_vld_in;
   logic [DOCID_BITS-1:0] thr_ff, thr_in;
   logic               thr_vld_ff, thr_vld_in;
   logic [ICW-1:0]     i_ff, i_in;
   logic [EW-1:0]      head_ff, head_in;
   logic               head_vld_ff, head_vld_in;
   logic [ICW-1:0]     out_ff, out_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [DOCID_BITS-1:0] rsp_docid_ff, rsp_docid_in;
   logic               rsp_pos_ff, rsp_pos_in;
   logic [ICW-1:0]     rsp_icount_ff, rsp_icount_in;
   logic [PCW-1:0]     rsp_pcount_ff, rsp_pcount_in;
   logic               rsp_merged_ff, rsp_merged_in;

   logic               p_we;
   logic [EW-1:0]      p_wdata, p_rdata;
   logic               i_we;
   logic [IAW-1:0]     i_raddr;
   logic [EW-1:0]      i_wdata, i_rdata, bank0_rdata, bank1_rdata;

   logic               accept, out_free;
   logic               pass, dup, full, trig, have_i, have_p, take_i, take_p;
   logic [EW-1:0]      entry;
   logic [PCW-1:0]     psize_add;
   logic [DOCID_BITS-1:0] scan_key, best_key, head_key;
   status_type         add_status;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign entry    = {req_docid, req_key_low_byte[0]};
   assign pass     = req_key_low_byte[1] || !req_key_low_byte[2];
   assign dup      = last_vld_ff && (entry == last_ff);
   assign full     = psize_ff == PCW'(PENDING_DEPTH);
   assign scan_key = p_rdata[EW-1:1];
   assign best_key = best_ff[EW-1:1];
   assign head_key = head_ff[EW-1:1];
   assign have_i   = i_ff < isize_ff;
   assign have_p   = best_vld_ff;
   assign take_p   = have_p && (!have_i || best_key <= head_key);
   assign take_i   = have_i && (!have_p || head_key <= best_key);
   assign i_rdata  = act_ff ? bank1_rdata : bank0_rdata;

   always_comb begin
      add_status = ST_OK;
      psize_add  = psize_ff;
      if (!pass || dup) begin
         add_status = ST_SKIP;
      end else if (full) begin
         add_status = ST_FULL;
      end else begin
         psize_add = psize_ff + PCW'(1);
      end
      trig = amen_ff && (psize_add != '0) && (LW'(psize_add) >= LW'(limit_ff));
   end

   always_comb begin
      p_we    = accept && (req_mode == MODE_ADD) && pass && !dup && !full;
      p_wdata = entry;
      i_we    = (state_ff == S_STEP) && (have_i || have_p) &&
                (out_ff != ICW'(INDEX_DEPTH));
      i_wdata = take_p ? best_ff : head_ff;
      i_raddr = (state_ff == S_IDLE) ? req_read_position : i_ff[IAW-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      amen_in       = amen_ff;
      limit_in      = limit_ff;
      isize_in      = isize_ff;
      psize_in      = psize_ff;
      last_in       = last_ff;
      last_vld_in   = last_vld_ff;
      act_in        = act_ff;
      saved_in      = saved_ff;
      scan_in       = scan_ff;
      cap_in        = 1'b0;
      best_in       = best_ff;
      best_vld_in   = best_vld_ff;
      thr_in        = thr_ff;
      thr_vld_in    = thr_vld_ff;
      i_in          = i_ff;
      head_in       = head_ff;
      head_vld_in   = head_vld_ff;
      out_in        = out_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_docid_in  = rsp_docid_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_icount_in = rsp_icount_ff;
      rsp_pcount_in = rsp_pcount_ff;
      rsp_merged_in = rsp_merged_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AUTO_MERGE: amen_in  = csr_data[0];
            CSR_LIMIT:      limit_in = csr_data;
            default:        ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_status_in = ST_OK;
               rsp_docid_in  = '0;
               rsp_pos_in    = 1'b0;
               rsp_merged_in = 1'b0;
               rsp_icount_in = isize_ff;
               rsp_pcount_in = psize_ff;
               saved_in      = ST_OK;
               case (req_mode)
                  MODE_ADD: begin
                     psize_in = psize_add;
                     if (p_we) begin
                        last_in     = entry;
                        last_vld_in = 1'b1;
                     end
                     saved_in = add_status;
                     if (trig) begin
                        state_in = S_PSCAN;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = add_status;
                        rsp_pcount_in = psize_add;
                     end
                  end
                  MODE_MERGE: begin
                     if (psize_ff != '0) begin
                        state_in = S_PSCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  MODE_READ: begin
                     if (ICW'(req_read_position) < isize_ff) begin
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BADPOS;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
               scan_in     = '0;
               best_vld_in = 1'b0;
               thr_vld_in  = 1'b0;
               i_in        = '0;
               head_vld_in = 1'b0;
               out_in      = '0;
            end
         end
         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_docid_in  = i_rdata[EW-1:1];
            rsp_pos_in    = i_rdata[0];
            state_in      = S_IDLE;
         end
         S_PSCAN: begin
            if (scan_ff < psize_ff) begin
               cap_in  = 1'b1;
               scan_in = scan_ff + PCW'(1);
            end
            if (cap_ff && (!thr_vld_ff || scan_key > thr_ff) &&
                (!best_vld_ff || scan_key <= best_key)) begin
               best_in     = p_rdata;
               best_vld_in = 1'b1;
            end
            if (scan_ff == psize_ff && !cap_ff) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            state_in = (!have_i || head_vld_ff) ? S_STEP : S_HCAP;
         end
         S_HCAP: begin
            head_in     = i_rdata;
            head_vld_in = 1'b1;
            state_in    = S_STEP;
         end
         S_STEP: begin
            if (!have_i && !have_p || out_ff == ICW'(INDEX_DEPTH)) begin
               // finish: flip banks and report
               isize_in      = out_ff;
               psize_in      = '0;
               act_in        = !act_ff;
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_merged_in = 1'b1;
               rsp_icount_in = out_ff;
               rsp_pcount_in = '0;
               rsp_status_in = (have_i || have_p) ? ST_OVF : saved_ff;
            end else begin
               out_in = out_ff + ICW'(1);
               if (take_i) begin
                  i_in        = i_ff + ICW'(1);
                  head_vld_in = 1'b0;
               end
               if (take_p) begin
                  thr_in      = best_key;
                  thr_vld_in  = 1'b1;
                  best_vld_in = 1'b0;
                  scan_in     = '0;
                  state_in    = S_PSCAN;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         amen_ff      <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         isize_ff     <= '0;
         psize_ff     <= '0;
         last_vld_ff  <= 1'b0;
         act_ff       <= 1'b0;
         cap_ff       <= 1'b0;
         best_vld_ff  <= 1'b0;
         thr_vld_ff   <= 1'b0;
         head_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         amen_ff      <= amen_in;
         limit_ff     <= limit_in;
         isize_ff     <= isize_in;
         psize_ff     <= psize_in;
         last_vld_ff  <= last_vld_in;
         act_ff       <= act_in;
         cap_ff       <= cap_in;
         best_vld_ff  <= best_vld_in;
         thr_vld_ff   <= thr_vld_in;
         head_vld_ff  <= head_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff       <= last_in;
      saved_ff      <= saved_in;
      scan_ff       <= scan_in;
      best_ff       <= best_in;
      thr_ff        <= thr_in;
      i_ff          <= i_in;
      head_ff       <= head_in;
      out_ff        <= out_in;
      rsp_status_ff <= rsp_status_in;
      rsp_docid_ff  <= rsp_docid_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_icount_ff <= rsp_icount_in;
      rsp_pcount_ff <= rsp_pcount_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_docid    = rsp_docid_ff;
   assign rsp_entry_positive = rsp_pos_ff;
   assign rsp_index_count    = rsp_icount_ff;
   assign rsp_pending_count  = rsp_pcount_ff;
   assign rsp_merged         = rsp_merged_ff;

   dsmi_ram #(.WIDTH(EW), .DEPTH(PENDING_DEPTH)) u_pending (
      .clock (clock),
      .we    (p_we),
      .waddr (psize_ff[PAW-1:0]),
      .wdata (p_wdata),
      .raddr (scan_ff[PAW-1:0]),
      .rdata (p_rdata)
   );

   dsmi_ram #(.WIDTH(EW), .DEPTH(INDEX_DEPTH)) u_bank0 (
      .clock (clock),
      .we    (i_we && act_ff),
      .waddr (out_ff[IAW-1:0]),
      .wdata (i_wdata),
      .raddr (i_raddr),
      .rdata (bank0_rdata)
   );

   dsmi_ram #(.WIDTH(EW), .DEPTH(INDEX_DEPTH)) u_bank1 (
      .clock (clock),
      .we    (i_we && !act_ff),
      .waddr (out_ff[IAW-1:0]),
      .wdata (i_wdata),
      .raddr (i_raddr),
      .rdata (bank1_rdata)
   );

   a_psize_max: assert property (@(posedge clock) disable iff (reset)
      psize_ff <= PCW'(PENDING_DEPTH))
      else $error("pending size above depth");

   a_isize_max: assert property (@(posedge clock) disable iff (reset)
      isize_ff <= ICW'(INDEX_DEPTH))
      else $error("index size above depth");

   a_merge_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_merged_ff |-> rsp_pcount_ff == '0)
      else $error("merge left pending entries");

   a_badpos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_BADPOS |-> rsp_docid_ff == '0 && !rsp_pos_ff)
      else $error("bad position carries entry data");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !accept)
      else $error("transfer taken during merge or read");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for docid_sorted_merge_index: a queue-fed driver and a monitor with
// random idling, checked against an in-bench sorted merge index predictor.
// Depends on dsmi_pkg and the docid_sorted_merge_index RTL.
module testbench;
   import dsmi_pkg::*;

   localparam int NDOC = 38;
   localparam mode_type MODE_NONE = 2'd3;
   localparam int TOTAL_ITEMS = 1850;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      mode_type         mode;
      logic [7:0]       kb;
      logic [NDOC-1:0]  docid;
      logic [9:0]       pos;
   } key_op_type;

   typedef struct {
      status_type       status;
      logic [NDOC-1:0]  docid;
      logic             positive;
      logic [10:0]      icount;
      logic [6:0]       pcount;
      logic             merged;
   } index_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   mode_type req_mode = MODE_ADD;
   logic [7:0] req_key_low_byte = 0;
   logic [NDOC-1:0] req_docid = 0;
   logic [9:0] req_read_position = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   status_type rsp_status;
   logic [NDOC-1:0] rsp_entry_docid;
   logic rsp_entry_positive;
   logic [10:0] rsp_index_count;
   logic [6:0] rsp_pending_count;
   logic rsp_merged;
   logic csr_valid = 0;
   logic csr_ready;
   csr_index_type csr_index = CSR_AUTO_MERGE;
   csr_data_type csr_data = 0;

   docid_sorted_merge_index dut (.*);

   key_op_type    op_queue[$];
   index_rsp_type rsp_expect[$];
   key_op_type    cur_op;
   int errors = 0;
   int sent_n = 0;
   int send_idle = 0;
   int recv_idle = 0;
   longint cycles = 0;

   logic [NDOC:0] index_mem[1024];
   logic [NDOC:0] pend_mem[64];
   int            index_n = 0;
   int            pend_n = 0;
   logic [NDOC:0] last_entry = 0;
   bit            last_ok = 0;
   bit            cfg_auto = 0;
   logic [6:0]    cfg_limit = LIMIT_RESET;

   logic [7:0]      gen_kb = 0;
   logic [NDOC-1:0] gen_doc = 0;

   initial forever #2 clock = ~clock;

   function automatic bit merge_pending();
      logic [NDOC:0] srt[64];
      logic [NDOC:0] outb[1024];
      logic [NDOC:0] v;
      int i, j, n, o;
      bit ovf;
      ovf = 0;
      o = 0;
      for (i = 0; i < pend_n; i++) srt[i] = pend_mem[i];
      for (i = 1; i < pend_n; i++) begin
         v = srt[i];
         j = i;
         while (j > 0 && srt[j-1][NDOC:1] > v[NDOC:1]) begin
            srt[j] = srt[j-1];
            j--;
         end
         srt[j] = v;
      end
      n = 0;
      for (i = 0; i < pend_n; i++) begin
         if (n > 0 && srt[n-1][NDOC:1] == srt[i][NDOC:1]) srt[n-1] = srt[i];
         else begin
            srt[n] = srt[i];
            n++;
         end
      end
      i = 0;
      j = 0;
      while (i < index_n || j < n) begin
         if (j >= n) v = index_mem[i++];
         else if (i >= index_n) v = srt[j++];
         else if (index_mem[i][NDOC:1] < srt[j][NDOC:1]) v = index_mem[i++];
         else if (index_mem[i][NDOC:1] > srt[j][NDOC:1]) v = srt[j++];
         else begin
            v = srt[j++];
            i++;
         end
         if (o < 1024) outb[o++] = v;
         else ovf = 1;
      end
      for (i = 0; i < o; i++) index_mem[i] = outb[i];
      index_n = o;
      pend_n = 0;
      return ovf;
   endfunction

   function automatic index_rsp_type predict_index(key_op_type op);
      index_rsp_type r;
      logic [NDOC:0] e;
      int lim;
      r = '{ST_OK, 0, 0, 0, 0, 0};
      lim = (cfg_limit == 0) ? 1 : int'(cfg_limit);
      case (op.mode)
         MODE_ADD: begin
            if (op.kb[1] || !op.kb[2]) begin
               e = {op.docid, op.kb[0]};
               if (last_ok && e == last_entry) r.status = ST_SKIP;
               else if (pend_n >= 64) r.status = ST_FULL;
               else begin
                  pend_mem[pend_n++] = e;
                  last_entry = e;
                  last_ok = 1;
               end
            end else r.status = ST_SKIP;
            if (cfg_auto && pend_n > 0 && pend_n >= lim) begin
               r.merged = 1;
               if (merge_pending()) r.status = ST_OVF;
            end
         end
         MODE_MERGE: begin
            if (pend_n > 0) begin
               r.merged = 1;
               if (merge_pending()) r.status = ST_OVF;
            end
         end
         MODE_READ: begin
            if (op.pos < index_n) begin
               r.docid = index_mem[op.pos][NDOC:1];
               r.positive = index_mem[op.pos][0];
            end else r.status = ST_BADPOS;
         end
         default: ;
      endcase
      r.icount = 11'(index_n);
      r.pcount = 7'(pend_n);
      return r;
   endfunction

   function automatic key_op_type rand_op(int merge_pct);
      key_op_type op;
      int sel;
      sel = $urandom_range(99);
      op.pos = $urandom_range(1) ? 10'($urandom_range(1023)) : 10'($urandom_range(index_n + 8));
      op.kb = 8'($urandom);
      op.docid = 0;
      if (sel < merge_pct) op.mode = MODE_MERGE;
      else if (sel < 73) begin
         op.mode = MODE_ADD;
         sel = $urandom_range(99);
         if (sel < 12) begin
            op.kb = gen_kb;
            op.docid = gen_doc;
         end else if (sel < 65) op.docid = NDOC'($urandom_range(1800));
         else if (sel < 80) op.docid = NDOC'({$urandom, $urandom});
         else if (sel < 90) op.docid = gen_doc + NDOC'($urandom_range(3));
         else op.docid = {NDOC{1'b1}} - NDOC'($urandom_range(3));
         gen_kb = op.kb;
         gen_doc = op.docid;
      end else if (sel < 98) op.mode = MODE_READ;
      else op.mode = MODE_NONE;
      return op;
   endfunction

   always @(posedge clock) begin
      if (reset) req_valid <= 0;
      else if (!req_valid || !req_stall) begin
         if (req_valid) rsp_expect.insert(rsp_expect.size(), predict_index(cur_op));
         if (op_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
            cur_op = op_queue.pop_front();
            req_mode <= cur_op.mode;
            req_key_low_byte <= cur_op.kb;
            req_docid <= cur_op.docid;
            req_read_position <= cur_op.pos;
            req_valid <= 1;
            sent_n++;
         end else req_valid <= 0;
      end
   end

   always @(posedge clock) begin
      index_rsp_type x;
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expect.size() == 0) begin
            $error("unexpected transfer on result channel");
            errors++;
         end else begin
            x = rsp_expect.pop_front();
            if (rsp_status !== x.status) begin
               $error("status exp %0d got %0d", x.status, rsp_status);
               errors++;
            end
            if (rsp_entry_docid !== x.docid) begin
               $error("entry_docid exp %0h got %0h", x.docid, rsp_entry_docid);
               errors++;
            end
            if (rsp_entry_positive !== x.positive) begin
               $error("entry_positive exp %0d got %0d", x.positive, rsp_entry_positive);
               errors++;
            end
            if (rsp_index_count !== x.icount) begin
               $error("index_count exp %0d got %0d", x.icount, rsp_index_count);
               errors++;
            end
            if (rsp_pending_count !== x.pcount) begin
               $error("pending_count exp %0d got %0d", x.pcount, rsp_pending_count);
               errors++;
            end
            if (rsp_merged !== x.merged) begin
               $error("merged exp %0d got %0d", x.merged, rsp_merged);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (sent_n < TOTAL_ITEMS / 3) begin
         send_idle = 18;
         recv_idle = 88;
      end else if (sent_n < 2 * TOTAL_ITEMS / 3) begin
         send_idle = 88;
         recv_idle = 18;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
   end

   task automatic push_op(mode_type m, logic [7:0] kb, logic [NDOC-1:0] d, logic [9:0] p);
      key_op_type op;
      op.mode = m;
      op.kb = kb;
      op.docid = d;
      op.pos = p;
      op_queue.insert(op_queue.size(), op);
   endtask

   task automatic drain();
      while (op_queue.size() > 0 || req_valid || rsp_expect.size() > 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, csr_data_type val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_AUTO_MERGE) cfg_auto = val[0];
      else cfg_limit = val;
   endtask

   initial begin
      bit            ph_auto[6] = '{0, 1, 1, 1, 1, 1};
      csr_data_type  ph_limit[6] = '{7'd127, 7'd64, 7'd0, 7'd1, 7'd127, 7'd23};
      int            ph_items[6] = '{500, 500, 40, 40, 300, 448};
      int            ph_merge[6] = '{1, 2, 2, 2, 1, 3};
      logic [NDOC-1:0] top;
      top = {NDOC{1'b1}};
      repeat (7) @(posedge clock);
      reset <= 0;
      push_op(MODE_READ, 8'h00, 0, 10'd0);
      push_op(MODE_MERGE, 8'h00, 0, 10'd0);
      push_op(MODE_NONE, 8'hFF, top, 10'h3FF);
      push_op(MODE_ADD, 8'h00, 0, 10'd0);
      push_op(MODE_ADD, 8'h00, 0, 10'd0);
      push_op(MODE_ADD, 8'h04, 38'd9, 10'd0);
      push_op(MODE_ADD, 8'h05, 38'd9, 10'd0);
      push_op(MODE_ADD, 8'h02, top, 10'd0);
      push_op(MODE_ADD, 8'h06, 38'd5, 10'd0);
      push_op(MODE_ADD, 8'h01, 38'd5, 10'd0);
      push_op(MODE_ADD, 8'hFF, 38'd5, 10'd0);
      push_op(MODE_ADD, 8'h03, 38'd7, 10'd0);
      push_op(MODE_MERGE, 8'h00, 0, 10'd0);
      push_op(MODE_READ, 8'h00, 0, 10'd0);
      push_op(MODE_READ, 8'h00, 0, 10'd1);
      push_op(MODE_READ, 8'h00, 0, 10'd2);
      push_op(MODE_READ, 8'h00, 0, 10'd3);
      push_op(MODE_READ, 8'h00, 0, 10'd4);
      push_op(MODE_READ, 8'h00, 0, 10'h3FF);
      push_op(MODE_ADD, 8'h00, 38'd7, 10'd0);
      push_op(MODE_ADD, 8'h01, 0, 10'd0);
      push_op(MODE_MERGE, 8'h00, 0, 10'd0);
      push_op(MODE_READ, 8'h00, 0, 10'd0);
      push_op(MODE_READ, 8'h00, 0, 10'd2);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_AUTO_MERGE, csr_data_type'(ph_auto[ph]));
         write_csr(CSR_LIMIT, ph_limit[ph]);
         for (int k = 0; k < ph_items[ph]; k++)
            op_queue.insert(op_queue.size(), rand_op(ph_merge[ph]));
         drain();
      end
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
